>>> rtl/trcm_pkg.sv
// shared types and constants for the toy rsa character modexp block
`timescale 1ns / 1ps

package trcm_pkg;

  localparam logic [15:0] MODULUS_RESET = 16'd319;
  localparam logic [7:0]  CHAR_OFFSET   = 8'd96;

  // command codes on in_cmd
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RED,
    ST_TEST,
    ST_DONE
  } state_t;

  // register that takes the reduced value when a reduction ends
  typedef enum logic [1:0] {
    TGT_BASE,
    TGT_ACC,
    TGT_SQR
  } tgt_t;

  typedef struct packed {
    logic load;
    logic mul;
    tgt_t tgt;
    logic red_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic e_zero;
    logic e_lsb;
    logic red_last;
  } dp_status_t;

endpackage

>>> rtl/trcm_ctrl.sv
// sequencer for square-and-multiply with shift-subtract reduction
`timescale 1ns / 1ps

module trcm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  trcm_pkg::dp_status_t  status,
  output trcm_pkg::ctrl_cmd_t   cmd,
  output logic                  busy
);
  import trcm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.tgt      = TGT_BASE;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RED;
        end
      end
      ST_RED: begin
        cmd.red_step = 1'b1;
        if (status.red_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status.e_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.mul   = 1'b1;
          cmd.tgt   = status.e_lsb ? TGT_ACC : TGT_SQR;
          state_nxt = ST_RED;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> rtl/trcm_dp.sv
// datapath: base prep, multiplier, bit-serial modular reducer, result format
`timescale 1ns / 1ps

module trcm_dp #(
  parameter int MW = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  trcm_pkg::ctrl_cmd_t    cmd,
  output trcm_pkg::dp_status_t   status,
  input  logic [MW-1:0]          m,
  input  logic                   in_cmd,
  input  logic signed [16:0]     in_value,
  input  logic [15:0]            in_exponent,
  input  logic                   in_last_in,
  output logic                   out_valid,
  output logic signed [16:0]     out_result,
  output logic                   out_last_out
);
  import trcm_pkg::*;

  localparam int PW = (2 * MW > 17) ? 2 * MW : 17;
  localparam int CW = $clog2(PW);

  logic          cmd_r, last_r, neg_r, eodd_r, ezero_r;
  logic [15:0]   exp_r;
  logic [MW-1:0] acc_r, mag_r, r_r;
  logic [PW-1:0] prod_r;
  logic [CW-1:0] cnt_r;
  tgt_t          tgt_r;
  logic          out_valid_r;
  logic [16:0]   out_result_r;
  logic          out_last_r;

  // base of the exponentiation
  logic [17:0]   base_enc, base_dec, base, base_mag;
  logic          base_neg;

  always_comb begin
    base_enc = {{10{in_value[7]}}, in_value[7:0]} - 18'(CHAR_OFFSET);
    base_dec = {in_value[16], in_value};
    base     = (in_cmd == CMD_DECRYPT) ? base_dec : base_enc;
    base_neg = base[17];
    base_mag = base_neg ? (18'd0 - base) : base;
  end

  // one restoring step of the reduction
  logic [MW:0]   r_sh, r_sub;
  logic [MW-1:0] r_step;

  always_comb begin
    r_sh   = {r_r, prod_r[PW-1]};
    r_sub  = r_sh - {1'b0, m};
    r_step = (r_sh >= {1'b0, m}) ? r_sub[MW-1:0] : r_sh[MW-1:0];
  end

  logic [2*MW-1:0] mult;
  logic [MW-1:0]   mult_a;

  always_comb begin
    mult_a = (cmd.tgt == TGT_ACC) ? acc_r : mag_r;
    mult   = mult_a * mag_r;
  end

  // result formatting
  logic [MW-1:0] mag_fin;
  logic [31:0]   mag_ext;
  logic [16:0]   v17, r17, dec17;
  logic          flip;

  always_comb begin
    if (ezero_r) begin
      mag_fin = MW'(1);
    end else if (m < MW'(2)) begin
      mag_fin = '0;
    end else begin
      mag_fin = acc_r;
    end
    mag_ext = 32'(mag_fin);
    v17     = mag_ext[16:0];
    flip    = neg_r & eodd_r & (mag_fin != '0);
    r17     = flip ? (17'd0 - v17) : v17;
    dec17   = r17 + 17'(CHAR_OFFSET);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_cmd;
      last_r  <= in_last_in;
      neg_r   <= base_neg;
      eodd_r  <= in_exponent[0];
      ezero_r <= (in_exponent == 16'd0);
      exp_r   <= in_exponent;
      acc_r   <= MW'(1);
      prod_r  <= PW'(base_mag[16:0]);
      r_r     <= '0;
      cnt_r   <= '0;
      tgt_r   <= TGT_BASE;
    end else if (cmd.mul) begin
      prod_r <= PW'(mult);
      r_r    <= '0;
      cnt_r  <= '0;
      tgt_r  <= cmd.tgt;
    end else if (cmd.red_step) begin
      prod_r <= {prod_r[PW-2:0], 1'b0};
      cnt_r  <= cnt_r + CW'(1);
      if (status.red_last) begin
        case (tgt_r)
          TGT_BASE: begin
            mag_r <= r_step;
          end
          TGT_ACC: begin
            acc_r <= r_step;
            exp_r <= {exp_r[15:1], 1'b0};
          end
          TGT_SQR: begin
            mag_r <= r_step;
            exp_r <= {1'b0, exp_r[15:1]};
          end
          default: begin
            mag_r <= r_step;
          end
        endcase
      end else begin
        r_r <= r_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_result_r <= (cmd_r == CMD_DECRYPT) ? {9'd0, dec17[7:0]} : r17;
      out_last_r   <= last_r;
    end
  end

  assign status.e_zero   = (exp_r == 16'd0);
  assign status.e_lsb    = exp_r[0];
  assign status.red_last = (cnt_r == CW'(PW - 1));

  assign out_valid    = out_valid_r;
  assign out_result   = out_result_r;
  assign out_last_out = out_last_r;

endmodule

>>> rtl/toy_rsa_char_modexp.sv
// top level of the toy rsa character modular exponentiation block
`timescale 1ns / 1ps

// usage
//  - input channel: drive in_cmd, in_value, in_exponent, in_last_in and raise start;
//    the transaction is taken at the clock edge where start is high and busy is low
//  - in_cmd 0 encrypts a character (base = signed byte - 96), 1 decrypts a residue
//  - result channel: out_valid pulses for one cycle with out_result and out_last_out;
//    the receiver has no back pressure and must take the result in that cycle
//  - config channel: cfg_modulus is written when cfg_valid and cfg_ready are high;
//    cfg_ready is always high, write it only while busy is low
//  - sequence: the product register is P = max(2*MOD_WIDTH, 17) bits wide; the base is
//    reduced first, then each square or multiply is a multiplier step followed by a
//    shift-subtract reduction over the P product bits; an exponent of L bits with k set
//    bits needs L-1 squares and k multiplies, followed by a last test and a finish step;
//    the bit-serial reducer sets the pace, and out_valid is registered from the finish step
//  - one item at a time: busy stays high until the result is produced, and a new
//    start may be given in the cycle that out_valid is high
//  - reset (rst_n low, synchronous) returns to idle, drops out_valid and sets the
//    modulus to 319

module toy_rsa_char_modexp #(
  parameter int MOD_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic signed [16:0] in_value,
  input  logic [15:0]        in_exponent,
  input  logic               in_last_in,
  output logic               out_valid,
  output logic signed [16:0] out_result,
  output logic               out_last_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_modulus
);
  import trcm_pkg::*;

  // modulus register, written by the config channel
  logic [15:0] modulus_r;
  logic [15:0] modulus_nxt;

  always_comb begin
    modulus_nxt = modulus_r;
    if (cfg_valid && cfg_ready) begin
      modulus_nxt = cfg_modulus;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
    end else begin
      modulus_r <= modulus_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  // modulus masked or zero-extended to the datapath width
  logic [31:0]          mod_ext;
  logic [MOD_WIDTH-1:0] m;

  assign mod_ext = {16'd0, modulus_r};
  assign m       = mod_ext[MOD_WIDTH-1:0];

  ctrl_cmd_t  cmd;
  dp_status_t status;

  trcm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  trcm_dp #(
    .MW (MOD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .m            (m),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .in_exponent  (in_exponent),
    .in_last_in   (in_last_in),
    .out_valid    (out_valid),
    .out_result   (out_result),
    .out_last_out (out_last_out)
  );

`ifndef SYNTHESIS
  // an accepted transaction makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // a result only appears once the sequencer is back in idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // every finish command yields exactly one result strobe
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finish without result strobe");

  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
`endif

endmodule
